// ----- rtl/ter_pkg.sv -----
// Shared constants, codes and types for the triangle edge rasterizer.
package ter_pkg;

	localparam int SUBPIXEL_BITS_DEF = 4;
	localparam int MAX_FRAME_DIM_DEF = 4096;

	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int XY_W     = 16;
	localparam int ZW_W     = 32;
	localparam int PIX_W    = 12;
	localparam int STEP_W   = 17;
	localparam int EDGE_W   = 32;
	localparam int AREA_W   = 35;
	localparam int MA_W     = 33;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 96;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// sequencer term numbering
	localparam logic [4:0] TERM_AREA    = 5'd12;
	localparam logic [4:0] TERM_PLANE_Z = 5'd14;
	localparam logic [4:0] TERM_PLANE_W = 5'd21;
	localparam logic [4:0] TERM_LAST    = 5'd27;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SH_NONE  = 2'd0,
		SH_FLOOR = 2'd1,
		SH_ROUND = 2'd2
	} shift_t;

	typedef enum logic [2:0] {
		CAP_NONE  = 3'd0,
		CAP_EDGE  = 3'd1,
		CAP_AREA  = 3'd2,
		CAP_DDX   = 3'd3,
		CAP_DDY   = 3'd4,
		CAP_START = 3'd5
	} cap_t;

	typedef struct packed {
		logic   clr;
		shift_t shift;
		logic   bias;
		cap_t   cap;
	} term_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_BOX  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_DIV  = 5'b10000
	} state_t;

endpackage

// ----- rtl/triangle_edge_rasterizer.sv -----
// Triangle edge rasterizer: setup sequencer with one shared multiplier, pixel walker.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tuser action, s_tdata vertex fields
//  m_      | out       | m_tvalid / m_tready | m_tdata pixel fields, m_tlast last pixel
//  cfg_    | in        | cfg_we              | cfg_index, cfg_data (frame size)
//
// A step result sits in the output register while the next request is taken,
// as long as the register drains. A start runs a box step, then 28
// multiply/accumulate terms (ST_MUL, then ST_ACC) on the shared multiplier, and
// four divisions in the bit-serial divider.
// Reset clears control state and walk registers except dx_q/dy_q; vertex storage is kept.
// s_tready drops for the whole setup and whenever a result waits unaccepted.
module triangle_edge_rasterizer import ter_pkg::*; #(
	parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF,
	parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// vertex_index, vertex_x, vertex_y, vertex_depth, vertex_inv_w, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_x, pixel_y, covered, depth, inv_w, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int S       = SUBPIXEL_BITS;
	localparam int COORD_W = $clog2(MAX_FRAME_DIM);
	localparam int MB_W    = (((COORD_W + S) > 17) ? (COORD_W + S) : 17) + 2;
	localparam int P_W     = MA_W + MB_W;
	localparam int ACC_W   = P_W + 2;
	localparam int DN_W    = ACC_W + S + 1;
	localparam int BOX_W   = ((COORD_W + 2) > 18) ? (COORD_W + 2) : 18;

	// input unpack
	logic                    in_acc;
	action_t                 in_act;
	logic [1:0]              in_vidx;
	logic signed [XY_W-1:0]  in_x, in_y;
	logic signed [ZW_W-1:0]  in_z, in_w;

	// configuration
	logic [CFG_W-1:0] fw_q, fh_q;

	// vertex store
	logic signed [XY_W-1:0] vx_q [3];
	logic signed [XY_W-1:0] vy_q [3];
	logic signed [ZW_W-1:0] vz_q [3];
	logic signed [ZW_W-1:0] vw_q [3];

	// setup state
	state_t                    state_q;
	logic [4:0]                t_q;
	logic signed [P_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [AREA_W-1:0]  area_q;
	logic                      div_neg_q;

	// walk state
	logic signed [STEP_W-1:0] dx_q [3];
	logic signed [STEP_W-1:0] dy_q [3];
	logic [EDGE_W-1:0]        erow_q [3];
	logic [EDGE_W-1:0]        epix_q [3];
	logic [ZW_W-1:0]          gdx_q [2];
	logic [ZW_W-1:0]          gdy_q [2];
	logic [ZW_W-1:0]          irow_q [2];
	logic [ZW_W-1:0]          ipix_q [2];
	logic [COORD_W-1:0]       minx_q, miny_q, maxx_q, maxy_q, posx_q, posy_q;
	logic                     active_q;

	// output register
	logic              ovalid_q;
	logic [PIX_W-1:0]  ox_q, oy_q;
	logic              ocov_q, olast_q;
	logic [ZW_W-1:0]   odep_q, oinw_q;

	assign in_acc  = s_tvalid && s_tready;
	assign in_act  = action_t'(s_tuser);
	assign in_vidx = s_tdata[1:0];
	assign in_x    = s_tdata[17:2];
	assign in_y    = s_tdata[33:18];
	assign in_z    = s_tdata[65:34];
	assign in_w    = s_tdata[97:66];

	assign s_tready = (state_q == ST_IDLE) && (!ovalid_q || m_tready);
	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {7'd0, oinw_q, odep_q, ocov_q, oy_q, ox_q};

	// ---------------------------------------------------------------
	// Bounding box: round vertex extremes to pixels, clamp to frame.
	// ---------------------------------------------------------------
	logic signed [XY_W-1:0]   lox, hix, loy, hiy;
	logic signed [XY_W:0]     rlox, rhix, rloy, rhiy;
	logic signed [BOX_W-1:0]  bminx, bmaxx, bminy, bmaxy, wdm1, htm1;
	logic [BOX_W-1:0]         fw_e, fh_e, wd_b, ht_b;
	logic                     box_empty;
	logic signed [STEP_W-1:0] edx [3];
	logic signed [STEP_W-1:0] edy [3];

	localparam logic signed [XY_W:0] RND_HALF = (XY_W+1)'(1 << (S - 1));
	localparam logic [BOX_W-1:0]     MAX_B    = BOX_W'(MAX_FRAME_DIM);

	always_comb begin
		lox = vx_q[0];
		hix = vx_q[0];
		loy = vy_q[0];
		hiy = vy_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < lox) lox = vx_q[i];
			if (vx_q[i] > hix) hix = vx_q[i];
			if (vy_q[i] < loy) loy = vy_q[i];
			if (vy_q[i] > hiy) hiy = vy_q[i];
		end
		rlox = ($signed({lox[XY_W-1], lox}) + RND_HALF) >>> S;
		rhix = ($signed({hix[XY_W-1], hix}) + RND_HALF) >>> S;
		rloy = ($signed({loy[XY_W-1], loy}) + RND_HALF) >>> S;
		rhiy = ($signed({hiy[XY_W-1], hiy}) + RND_HALF) >>> S;

		// frame size register: zero reads as one, large values saturate
		fw_e = BOX_W'(fw_q);
		fh_e = BOX_W'(fh_q);
		wd_b = (fw_q == '0) ? BOX_W'(1) : ((fw_e > MAX_B) ? MAX_B : fw_e);
		ht_b = (fh_q == '0) ? BOX_W'(1) : ((fh_e > MAX_B) ? MAX_B : fh_e);
		wdm1 = $signed(wd_b) - BOX_W'(1);
		htm1 = $signed(ht_b) - BOX_W'(1);

		bminx = BOX_W'(rlox);
		bminy = BOX_W'(rloy);
		bmaxx = BOX_W'(rhix);
		bmaxy = BOX_W'(rhiy);
		if (bminx < 0) bminx = '0;
		if (bminy < 0) bminy = '0;
		if (bmaxx > wdm1) bmaxx = wdm1;
		if (bmaxy > htm1) bmaxy = htm1;
		box_empty = (bminx > bmaxx) || (bminy > bmaxy);

		for (int i = 0; i < 3; i++) begin
			edx[i] = STEP_W'(vx_q[(i + 1) % 3]) - STEP_W'(vx_q[i]);
			edy[i] = STEP_W'(vy_q[(i + 1) % 3]) - STEP_W'(vy_q[i]);
		end
	end

	// ---------------------------------------------------------------
	// Term decode: operands and control for the shared multiplier.
	// ---------------------------------------------------------------
	logic [1:0]               e;
	logic                     pl;
	logic [4:0]               kk5;
	logic [2:0]               kk;
	logic signed [STEP_W-1:0] sdx, sdy, x10, x20, y10, y20;
	logic signed [XY_W-1:0]   sxi, syi;
	logic                     sbias;
	logic signed [ZW_W-1:0]   u0, u1, u2;
	logic signed [MA_W-1:0]   u10, u20;
	logic signed [MB_W-1:0]   ofsx, ofsy;
	logic signed [MA_W-1:0]   op_a;
	logic signed [MB_W-1:0]   op_b;
	term_ctl_t                ctl;

	always_comb begin
		e   = t_q[3:2];
		pl  = t_q >= TERM_PLANE_W;
		kk5 = pl ? (t_q - TERM_PLANE_W) : (t_q - TERM_PLANE_Z);
		kk  = kk5[2:0];

		case (e)
			2'd0: begin sdx = dx_q[0]; sdy = dy_q[0]; sxi = vx_q[0]; syi = vy_q[0]; end
			2'd1: begin sdx = dx_q[1]; sdy = dy_q[1]; sxi = vx_q[1]; syi = vy_q[1]; end
			default: begin sdx = dx_q[2]; sdy = dy_q[2]; sxi = vx_q[2]; syi = vy_q[2]; end
		endcase
		// top-left fill bias
		sbias = (sdy < 0) || ((sdy == 0) && (sdx > 0));

		x10 = STEP_W'(vx_q[1]) - STEP_W'(vx_q[0]);
		x20 = STEP_W'(vx_q[2]) - STEP_W'(vx_q[0]);
		y10 = STEP_W'(vy_q[1]) - STEP_W'(vy_q[0]);
		y20 = STEP_W'(vy_q[2]) - STEP_W'(vy_q[0]);

		u0  = pl ? vw_q[0] : vz_q[0];
		u1  = pl ? vw_q[1] : vz_q[1];
		u2  = pl ? vw_q[2] : vz_q[2];
		u10 = MA_W'(u1) - MA_W'(u0);
		u20 = MA_W'(u2) - MA_W'(u0);

		ofsx = (MB_W'($signed({1'b0, minx_q})) <<< S) - MB_W'(vx_q[0]);
		ofsy = (MB_W'($signed({1'b0, miny_q})) <<< S) - MB_W'(vy_q[0]);

		op_a = '0;
		op_b = '0;
		ctl  = '{clr: 1'b0, shift: SH_NONE, bias: 1'b0, cap: CAP_NONE};

		if (t_q < TERM_AREA) begin
			case (t_q[1:0])
				2'd0: begin
					op_a = MA_W'(sdx);
					op_b = -MB_W'(syi);
					ctl.clr = 1'b1;
					ctl.shift = SH_FLOOR;
				end
				2'd1: begin
					op_a = MA_W'(sdy);
					op_b = MB_W'(sxi);
					ctl.shift = SH_FLOOR;
					ctl.bias = sbias;
				end
				2'd2: begin
					op_a = MA_W'(sdx);
					op_b = MB_W'($signed({1'b0, miny_q}));
				end
				default: begin
					op_a = MA_W'(sdy);
					op_b = -MB_W'($signed({1'b0, minx_q}));
					ctl.cap = CAP_EDGE;
				end
			endcase
		end else if (t_q < TERM_PLANE_Z) begin
			if (t_q == TERM_AREA) begin
				op_a = MA_W'(x10);
				op_b = MB_W'(y20);
				ctl.clr = 1'b1;
			end else begin
				op_a = MA_W'(x20);
				op_b = -MB_W'(y10);
				ctl.cap = CAP_AREA;
			end
		end else begin
			case (kk)
				3'd0: begin
					op_a = u10;
					op_b = MB_W'(y20);
					ctl.clr = 1'b1;
				end
				3'd1: begin
					op_a = u20;
					op_b = -MB_W'(y10);
					ctl.cap = CAP_DDX;
				end
				3'd2: begin
					op_a = u20;
					op_b = MB_W'(x10);
					ctl.clr = 1'b1;
				end
				3'd3: begin
					op_a = u10;
					op_b = -MB_W'(x20);
					ctl.cap = CAP_DDY;
				end
				3'd4: begin
					op_a = MA_W'(u0);
					op_b = MB_W'(1);
					ctl.clr = 1'b1;
				end
				3'd5: begin
					op_a = MA_W'($signed(gdx_q[pl]));
					op_b = ofsx;
					ctl.shift = SH_ROUND;
				end
				default: begin
					op_a = MA_W'($signed(gdy_q[pl]));
					op_b = ofsy;
					ctl.shift = SH_ROUND;
					ctl.cap = CAP_START;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Accumulator, divider feed and saturation.
	// ---------------------------------------------------------------
	logic signed [ACC_W-1:0]  prod_e, addend, acc_nx;
	logic signed [DN_W-1:0]   n16;
	logic [DN_W-1:0]          nmag, div_dividend, div_quo;
	logic [AREA_W-1:0]        cmag;
	logic                     div_start, div_done;
	logic [ZW_W-1:0]          acc_sat, grad;

	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (S - 1));
	localparam logic [DN_W-1:0]         Q_MAXP   = DN_W'(32'h7fff_ffff);
	localparam logic [DN_W-1:0]         Q_MAXN   = DN_W'(33'h0_8000_0000);

	always_comb begin
		prod_e = ACC_W'(prod_q);
		case (ctl.shift)
			SH_FLOOR: addend = prod_e >>> S;
			SH_ROUND: addend = (prod_e + ACC_HALF) >>> S;
			default:  addend = prod_e;
		endcase
		acc_nx = (ctl.clr ? '0 : acc_q) + addend + ACC_W'({1'b0, ctl.bias});

		n16  = DN_W'(acc_nx) <<< S;
		nmag = n16[DN_W-1] ? DN_W'(-n16) : DN_W'(n16);
		cmag = area_q[AREA_W-1] ? AREA_W'(-area_q) : AREA_W'(area_q);
		div_dividend = nmag + DN_W'(cmag >> 1);
		div_start = (state_q == ST_ACC) && ((ctl.cap == CAP_DDX) || (ctl.cap == CAP_DDY));

		// clamp to 32 bits when the upper bits are not all sign
		if ((&acc_nx[ACC_W-1:ZW_W-1]) || !(|acc_nx[ACC_W-1:ZW_W-1]))
			acc_sat = acc_nx[ZW_W-1:0];
		else
			acc_sat = acc_nx[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;

		if (area_q == '0)
			grad = '0;
		else if (!div_neg_q)
			grad = (div_quo > Q_MAXP) ? 32'h7fff_ffff : div_quo[ZW_W-1:0];
		else
			grad = (div_quo > Q_MAXN) ? 32'h8000_0000 : (32'd0 - div_quo[ZW_W-1:0]);
	end

	ter_div #(
		.N_W (DN_W),
		.D_W (AREA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cmag),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------
	// Walk step values.
	// ---------------------------------------------------------------
	logic step_go, step_last, step_cov;

	always_comb begin
		step_go   = in_acc && (in_act == ACT_STEP) && active_q;
		step_last = (posx_q == maxx_q) && (posy_q == maxy_q);
		step_cov  = ($signed(epix_q[0]) > 0) && ($signed(epix_q[1]) > 0) &&
			($signed(epix_q[2]) > 0);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data;
				REG_FRAME_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// vertex loads; index three is dropped
	always_ff @(posedge clk) begin
		if (in_acc && (in_act == ACT_LOAD) && (in_vidx != 2'd3)) begin
			vx_q[in_vidx] <= in_x;
			vy_q[in_vidx] <= in_y;
			vz_q[in_vidx] <= in_z;
			vw_q[in_vidx] <= in_w;
		end
	end

	// the product lands in prod_q, the sum goes through acc_q; sign, area and edge steps are captured too
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL)
			prod_q <= op_a * op_b;
		if (state_q == ST_ACC)
			acc_q <= acc_nx;
		if (div_start)
			div_neg_q <= acc_nx[ACC_W-1] ^ area_q[AREA_W-1];
		if ((state_q == ST_ACC) && (ctl.cap == CAP_AREA))
			area_q <= acc_nx[AREA_W-1:0];
		if (state_q == ST_BOX) begin
			for (int i = 0; i < 3; i++) begin
				dx_q[i] <= edx[i];
				dy_q[i] <= edy[i];
			end
		end
	end

	// sequencer, walk registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			t_q      <= '0;
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			ocov_q   <= 1'b0;
			odep_q   <= '0;
			oinw_q   <= '0;
			olast_q  <= 1'b0;
			minx_q   <= '0;
			miny_q   <= '0;
			maxx_q   <= '0;
			maxy_q   <= '0;
			posx_q   <= '0;
			posy_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				erow_q[i] <= '0;
				epix_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				gdx_q[i]  <= '0;
				gdy_q[i]  <= '0;
				irow_q[i] <= '0;
				ipix_q[i] <= '0;
			end
		end else begin
			// load a new result, or drop the one the receiver took
			if (step_go)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_act == ACT_START)) begin
						// a new start replaces any walk in progress
						active_q <= 1'b0;
						state_q  <= ST_BOX;
					end
					if (step_go) begin
						ox_q     <= PIX_W'(posx_q);
						oy_q     <= PIX_W'(posy_q);
						ocov_q   <= step_cov;
						odep_q   <= ipix_q[0];
						oinw_q   <= ipix_q[1];
						olast_q  <= step_last;
						if (step_last) begin
							active_q <= 1'b0;
						end else if (posx_q < maxx_q) begin
							// advance one pixel along the row
							posx_q <= posx_q + COORD_W'(1);
							for (int i = 0; i < 3; i++)
								epix_q[i] <= epix_q[i] - EDGE_W'(dy_q[i]);
							ipix_q[0] <= ipix_q[0] + gdx_q[0];
							ipix_q[1] <= ipix_q[1] + gdx_q[1];
						end else begin
							// wrap to the start of the next row
							posx_q <= minx_q;
							posy_q <= posy_q + COORD_W'(1);
							for (int i = 0; i < 3; i++) begin
								erow_q[i] <= erow_q[i] + EDGE_W'(dx_q[i]);
								epix_q[i] <= erow_q[i] + EDGE_W'(dx_q[i]);
							end
							for (int i = 0; i < 2; i++) begin
								irow_q[i] <= irow_q[i] + gdy_q[i];
								ipix_q[i] <= irow_q[i] + gdy_q[i];
							end
						end
					end
				end

				ST_BOX: begin
					if (box_empty) begin
						state_q <= ST_IDLE;
					end else begin
						minx_q  <= COORD_W'(bminx);
						miny_q  <= COORD_W'(bminy);
						maxx_q  <= COORD_W'(bmaxx);
						maxy_q  <= COORD_W'(bmaxy);
						t_q     <= '0;
						state_q <= ST_MUL;
					end
				end

				ST_MUL: state_q <= ST_ACC;

				ST_ACC: begin
					case (ctl.cap)
						CAP_EDGE: begin
							erow_q[e] <= acc_nx[EDGE_W-1:0];
							epix_q[e] <= acc_nx[EDGE_W-1:0];
						end
						CAP_START: begin
							irow_q[pl] <= acc_sat;
							ipix_q[pl] <= acc_sat;
						end
						default: ;
					endcase
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (t_q == TERM_LAST) begin
						// setup done: open the walk at the top-left box corner
						active_q <= 1'b1;
						posx_q   <= minx_q;
						posy_q   <= miny_q;
						state_q  <= ST_IDLE;
					end else begin
						t_q     <= t_q + 5'd1;
						state_q <= ST_MUL;
					end
				end

				ST_DIV: begin
					if (div_done) begin
						if (ctl.cap == CAP_DDX)
							gdx_q[pl] <= grad;
						else
							gdy_q[pl] <= grad;
						t_q     <= t_q + 5'd1;
						state_q <= ST_MUL;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/ter_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module ter_div #(
	parameter int N_W = 59,
	parameter int D_W = 35
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [D_W:0]     rem_sh;
	logic [D_W:0]     rem_nx;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[N_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= rem_nx[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
